// ===== rtl/clcd_pkg.sv =====
`timescale 1ns / 1ps

package clcd_pkg;

    localparam int WAIT_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWERUP_WAIT = 2'd2;

    localparam logic [WAIT_W-1:0] SHORT_WAIT_RST   = 16'd40;
    localparam logic [WAIT_W-1:0] LONG_WAIT_RST    = 16'd2000;
    localparam logic [WAIT_W-1:0] POWERUP_WAIT_RST = 16'd14000;
    localparam logic [WAIT_W-1:0] WAIT_MAX         = 16'hFFFF;

    localparam logic [STEP_W-1:0] NIB_STEPS = 4'd4;
    localparam logic [STEP_W-1:0] INIT_DONE = 4'd8;

    localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_HOME  = 8'h02;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [6:0] {
        PH_POWERUP = 7'b0000001,
        PH_N1_HIGH = 7'b0000010,
        PH_N1_LOW  = 7'b0000100,
        PH_N2_HIGH = 7'b0001000,
        PH_N2_LOW  = 7'b0010000,
        PH_WAIT    = 7'b0100000,
        PH_IDLE    = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [WAIT_W-1:0]   wait_count;
        logic [STEP_W-1:0]   init_step;
        logic [BYTE_W-1:0]   held_byte;
        logic                held_rs;
        logic                rs;
        logic                en;
        logic [NIB_W-1:0]    nib;
    } t_state;

    typedef struct packed {
        logic                req_type;
        logic [BYTE_W-1:0]   write_byte;
        logic                is_data;
    } t_item;

    typedef struct packed {
        logic [WAIT_W-1:0]   short_wait;
        logic [WAIT_W-1:0]   long_wait;
        logic [WAIT_W-1:0]   powerup_wait;
    } t_cfg;

    typedef struct packed {
        logic                pin_rs;
        logic                pin_en;
        logic [NIB_W-1:0]    pin_nibble;
        logic                busy_res;
        logic                write_dropped;
    } t_result;

    // Fixed power-on sequence: three wake-up nibbles, 4-bit mode, then set-up commands
    function automatic logic [BYTE_W-1:0] init_item(input logic [2:0] step);
        logic [BYTE_W-1:0] b;
        case (step)
            3'd0, 3'd1, 3'd2: b = 8'h30;
            3'd3:             b = 8'h20;
            3'd4:             b = 8'h28;
            3'd5:             b = 8'h06;
            3'd6:             b = 8'h0C;
            default:          b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/clcd_if.sv =====
`timescale 1ns / 1ps

interface clcd_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [clcd_pkg::BYTE_W-1:0] write_byte;
    logic                        is_data;

    modport source (output valid, output req_type, output write_byte, output is_data,
                    input ready);
    modport sink   (input valid, input req_type, input write_byte, input is_data,
                    output ready);
endinterface

interface clcd_res_if;
    logic                       valid;
    logic                       ready;
    logic                       pin_rs;
    logic                       pin_en;
    logic [clcd_pkg::NIB_W-1:0] pin_nibble;
    logic                       busy_res;
    logic                       write_dropped;

    modport source (output valid, output pin_rs, output pin_en, output pin_nibble,
                    output busy_res, output write_dropped, input ready);
    modport sink   (input valid, input pin_rs, input pin_en, input pin_nibble,
                    input busy_res, input write_dropped, output ready);
endinterface

interface clcd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [clcd_pkg::CFG_IDX_W-1:0] index;
    logic [clcd_pkg::WAIT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/clcd_step.sv =====
`timescale 1ns / 1ps

module clcd_step (
    input  clcd_pkg::t_state  i_state,
    input  clcd_pkg::t_item   i_item,
    input  clcd_pkg::t_cfg    i_cfg,
    output clcd_pkg::t_state  o_state,
    output clcd_pkg::t_result o_result
);
    import clcd_pkg::*;

    logic [WAIT_W-1:0] cnt_inc;
    logic [WAIT_W-1:0] target;
    logic [STEP_W-1:0] step_inc;
    logic [BYTE_W-1:0] first_init_byte;
    logic [BYTE_W-1:0] next_init_byte;
    logic              dropped;

    // Saturating tick count and the wait length that applies to the held byte
    assign cnt_inc  = (i_state.wait_count == WAIT_MAX) ? i_state.wait_count
                                                       : i_state.wait_count + 16'd1;
    assign step_inc = i_state.init_step + 4'd1;
    assign first_init_byte = init_item(3'd0);
    assign next_init_byte  = init_item(step_inc[2:0]);

    always_comb begin
        if (i_state.init_step < NIB_STEPS) begin
            target = i_cfg.long_wait;
        end else if (!i_state.held_rs &&
                     (i_state.held_byte == CMD_CLEAR || i_state.held_byte == CMD_HOME)) begin
            target = i_cfg.long_wait;
        end else begin
            target = i_cfg.short_wait;
        end
    end

    always_comb begin
        o_state = i_state;
        dropped = 1'b0;
        if (i_item.req_type == REQ_WRITE) begin
            // Take a byte only while idle, otherwise drop and flag it
            if (i_state.phase == PH_IDLE) begin
                o_state.held_byte = i_item.write_byte;
                o_state.held_rs   = i_item.is_data;
                o_state.rs        = i_item.is_data;
                o_state.en        = 1'b1;
                o_state.nib       = i_item.write_byte[7:4];
                o_state.phase     = PH_N1_HIGH;
            end else begin
                dropped = 1'b1;
            end
        end else begin
            unique case (i_state.phase)
                PH_POWERUP: begin
                    if (cnt_inc >= i_cfg.powerup_wait) begin
                        o_state.wait_count = '0;
                        o_state.init_step  = '0;
                        o_state.held_byte  = first_init_byte;
                        o_state.held_rs    = 1'b0;
                        o_state.rs         = 1'b0;
                        o_state.en         = 1'b1;
                        o_state.nib        = first_init_byte[7:4];
                        o_state.phase      = PH_N1_HIGH;
                    end else begin
                        o_state.wait_count = cnt_inc;
                    end
                end
                PH_N1_HIGH: begin
                    o_state.en    = 1'b0;
                    o_state.phase = PH_N1_LOW;
                end
                PH_N1_LOW: begin
                    // Wake-up and 4-bit mode nibbles are sent alone
                    if (i_state.init_step < NIB_STEPS) begin
                        o_state.wait_count = '0;
                        o_state.phase      = PH_WAIT;
                    end else begin
                        o_state.en    = 1'b1;
                        o_state.nib   = i_state.held_byte[3:0];
                        o_state.phase = PH_N2_HIGH;
                    end
                end
                PH_N2_HIGH: begin
                    o_state.en    = 1'b0;
                    o_state.phase = PH_N2_LOW;
                end
                PH_N2_LOW: begin
                    o_state.wait_count = '0;
                    o_state.phase      = PH_WAIT;
                end
                PH_WAIT: begin
                    if (cnt_inc >= target) begin
                        o_state.wait_count = '0;
                        o_state.phase      = PH_IDLE;
                        if (i_state.init_step < INIT_DONE) begin
                            o_state.init_step = step_inc;
                            // Start the next init item on the same tick
                            if (step_inc < INIT_DONE) begin
                                o_state.held_byte = next_init_byte;
                                o_state.held_rs   = 1'b0;
                                o_state.rs        = 1'b0;
                                o_state.en        = 1'b1;
                                o_state.nib       = next_init_byte[7:4];
                                o_state.phase     = PH_N1_HIGH;
                            end
                        end
                    end else begin
                        o_state.wait_count = cnt_inc;
                    end
                end
                PH_IDLE: begin
                    o_state.phase = PH_IDLE;
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_result.pin_rs        = o_state.rs;
    assign o_result.pin_en        = o_state.en;
    assign o_result.pin_nibble    = o_state.nib;
    assign o_result.busy_res      = (o_state.phase != PH_IDLE);
    assign o_result.write_dropped = dropped;

endmodule

// ===== rtl/char_lcd_4bit_write_sequencer.sv =====
`timescale 1ns / 1ps

// Four-bit character LCD write sequencer.
// i_req carries items: a tick (req_type 0) lets one unit of time pass, a
// write (req_type 1) sends write_byte with register select from is_data.
// o_res returns one item per request: the RS, EN and D7..D4 line levels
// after it, a busy flag and a flag for a write that was dropped because
// the block was still busy.
// i_cfg writes the short, long and power-up wait lengths (index 0, 1, 2),
// always ready; write it only while no item is in flight.
// Throughput: one item per cycle while i_req.ready is high. Results are
// registered; the state update is one pass through the step logic
// between the state and result registers.
// A two-entry output buffer (result register plus skid) lets an item be
// taken while a result waits; i_req.ready drops only when both entries
// are full, so a stalled receiver holds the sender after one more item.
// Reset restores the wait defaults and starts the power-up wait; the init
// sequence then runs, driven by ticks, before writes are taken.
module char_lcd_4bit_write_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    clcd_req_if.sink       i_req,
    clcd_res_if.source     o_res,
    clcd_cfg_if.sink       i_cfg
);
    import clcd_pkg::*;

    t_state  r_st;
    t_state  n_st;
    t_cfg    r_cfg;
    t_item   item;
    t_result n_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_v;
    logic    r_skid_v;
    logic    acc;
    logic    out_fire;

    assign item.req_type   = i_req.req_type;
    assign item.write_byte = i_req.write_byte;
    assign item.is_data    = i_req.is_data;

    clcd_step u_step (
        .i_state  (r_st),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_state  (n_st),
        .o_result (n_res)
    );

    assign i_req.ready = !r_skid_v;
    assign i_cfg.ready = 1'b1;
    assign acc      = i_req.valid && i_req.ready;
    assign out_fire = r_out_v && o_res.ready;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_wait   <= SHORT_WAIT_RST;
            r_cfg.long_wait    <= LONG_WAIT_RST;
            r_cfg.powerup_wait <= POWERUP_WAIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SHORT_WAIT:   r_cfg.short_wait   <= i_cfg.data;
                CFG_LONG_WAIT:    r_cfg.long_wait    <= i_cfg.data;
                CFG_POWERUP_WAIT: r_cfg.powerup_wait <= i_cfg.data;
                default:          ;
            endcase
        end
    end

    // Advance the sequencer state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase      <= PH_POWERUP;
            r_st.wait_count <= '0;
            r_st.init_step  <= '0;
            r_st.held_byte  <= '0;
            r_st.held_rs    <= 1'b0;
            r_st.rs         <= 1'b0;
            r_st.en         <= 1'b0;
            r_st.nib        <= '0;
        end else if (acc) begin
            r_st <= n_st;
        end
    end

    // Output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else if (!acc) begin
                r_out_v <= 1'b0;
            end
        end else if (acc) begin
            if (!r_out_v) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (acc) begin
                r_out <= n_res;
            end
        end else if (acc) begin
            if (!r_out_v) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.pin_rs        = r_out.pin_rs;
    assign o_res.pin_en        = r_out.pin_en;
    assign o_res.pin_nibble    = r_out.pin_nibble;
    assign o_res.busy_res      = r_out.busy_res;
    assign o_res.write_dropped = r_out.write_dropped;

    // The skid entry is only ever filled behind a full result register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid without result register");

    // An idle write starts the first nibble with the strobe high
    a_write_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == REQ_WRITE && r_st.phase == PH_IDLE)
        |=> (r_st.phase == PH_N1_HIGH && r_st.en))
        else $error("accepted write did not start a transfer");

    // A busy write leaves the sequencer untouched
    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == REQ_WRITE && r_st.phase != PH_IDLE)
        |=> (r_st == $past(r_st)))
        else $error("dropped write changed the state");

    // The strobe is high only in a nibble high phase
    a_en_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.en |-> (r_st.phase == PH_N1_HIGH || r_st.phase == PH_N2_HIGH))
        else $error("enable high outside a strobe phase");

    a_init_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.init_step <= INIT_DONE)
        else $error("init step out of range");

endmodule
